### rtl/bcc_pkg.sv
`default_nettype none
package bcc_pkg;

    // codeword geometry
    localparam int NumPos  = 16;
    localparam int NumRows = 8;
    localparam int PosW    = $clog2(NumPos);

    // position field code for no correction
    localparam logic [4:0] POS_NONE = 5'd16;
    localparam logic [PosW-1:0] POS_LAST = PosW'(NumPos - 1);
    localparam logic [PosW-1:0] POS_PAIR_LAST_I = PosW'(NumPos - 2);

    // configuration register space
    localparam int AddrW = 5;

    typedef logic [NumRows-1:0][NumPos-1:0] t_rows;

    typedef enum logic [1:0] {
        ST_CLEAN   = 2'd0,
        ST_SINGLE  = 2'd1,
        ST_DOUBLE  = 2'd2,
        ST_UNCORR  = 2'd3
    } t_status;

    typedef struct packed {
        logic [NumPos-1:0] code_word;
        t_status           status;
        logic [4:0]        first_position;
        logic [4:0]        second_position;
    } t_result;

    // column n of the check matrix, bit r taken from row r
    function automatic logic [NumRows-1:0] col_of(input t_rows rows,
                                                  input logic [PosW-1:0] n);
        logic [NumRows-1:0] c;
        c = '0;
        for (int r = 0; r < NumRows; r++) begin
            c[r] = rows[r][n];
        end
        return c;
    endfunction

endpackage
`default_nettype wire

### rtl/bcc_regs.sv
`default_nettype none
module bcc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bcc_pkg::AddrW-1:0]     paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output bcc_pkg::t_rows                     o_rows
);

    bcc_pkg::t_rows   r_rows;
    logic [2:0]       reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    // check row registers, written in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else if (psel && penable && pwrite) begin
            r_rows[reg_idx] <= pwdata[15:0];
        end
    end

    // read back
    assign prdata = {16'd0, r_rows[reg_idx]};
    assign o_rows = r_rows;

endmodule
`default_nettype wire

### rtl/bcc_core.sv
`default_nettype none
module bcc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bcc_pkg::t_rows    i_rows,
    input  wire logic              i_start,
    input  wire logic              i_action,
    input  wire logic [7:0]        i_data_byte,
    input  wire logic [15:0]       i_received_word,
    input  wire logic              i_res_taken,
    output logic                   o_idle,
    output logic                   o_res_valid,
    output bcc_pkg::t_result       o_res
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SINGLE = 4'b0010,
        S_PAIR   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [3:0]        r_i, n_i;
    logic [3:0]        r_k, n_k;
    logic [7:0]        r_syn, n_syn;
    logic [15:0]       r_word, n_word;
    bcc_pkg::t_status  r_status, n_status;
    logic [4:0]        r_p1, n_p1;
    logic [4:0]        r_p2, n_p2;

    logic [15:0]       enc_word;
    logic [7:0]        syn_in;
    logic [7:0]        cmp_a;
    logic [7:0]        cmp_b;
    logic              hit;

    // encoder: message reversed into positions 0..7, parity above
    always_comb begin
        enc_word = '0;
        for (int n = 0; n < 8; n++) begin
            enc_word[n] = i_data_byte[7-n];
        end
        for (int r = 0; r < bcc_pkg::NumRows; r++) begin
            enc_word[8+r] = ^(enc_word[7:0] & i_rows[r][7:0]);
        end
    end

    // syndrome of the received word
    always_comb begin
        for (int r = 0; r < bcc_pkg::NumRows; r++) begin
            syn_in[r] = ^(i_received_word & i_rows[r]);
        end
    end

    // shared compare unit: one column or one column pair per cycle
    assign cmp_a = bcc_pkg::col_of(i_rows, r_i);
    assign cmp_b = (r_state == S_PAIR) ? bcc_pkg::col_of(i_rows, r_k) : 8'd0;
    assign hit   = ((cmp_a ^ cmp_b) == r_syn);

    // search sequencer
    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_k      = r_k;
        n_syn    = r_syn;
        n_word   = r_word;
        n_status = r_status;
        n_p1     = r_p1;
        n_p2     = r_p2;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_p1     = bcc_pkg::POS_NONE;
                    n_p2     = bcc_pkg::POS_NONE;
                    n_status = bcc_pkg::ST_CLEAN;
                    n_i      = '0;
                    n_syn    = syn_in;
                    if (!i_action) begin
                        n_word  = enc_word;
                        n_state = S_DONE;
                    end else begin
                        n_word  = i_received_word;
                        n_state = (syn_in == 8'd0) ? S_DONE : S_SINGLE;
                    end
                end
            end
            S_SINGLE: begin
                if (hit) begin
                    n_status = bcc_pkg::ST_SINGLE;
                    n_p1     = {1'b0, r_i};
                    n_word   = r_word ^ (16'd1 << r_i);
                    n_state  = S_DONE;
                end else if (r_i == bcc_pkg::POS_LAST) begin
                    n_i     = 4'd0;
                    n_k     = 4'd1;
                    n_state = S_PAIR;
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            S_PAIR: begin
                if (hit) begin
                    n_status = bcc_pkg::ST_DOUBLE;
                    n_p1     = {1'b0, r_i};
                    n_p2     = {1'b0, r_k};
                    n_word   = r_word ^ (16'd1 << r_i) ^ (16'd1 << r_k);
                    n_state  = S_DONE;
                end else if (r_k == bcc_pkg::POS_LAST) begin
                    if (r_i == bcc_pkg::POS_PAIR_LAST_I) begin
                        n_status = bcc_pkg::ST_UNCORR;
                        n_state  = S_DONE;
                    end else begin
                        n_i = r_i + 4'd1;
                        n_k = r_i + 4'd2;
                    end
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_DONE: begin
                if (i_res_taken) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_i      <= n_i;
        r_k      <= n_k;
        r_syn    <= n_syn;
        r_word   <= n_word;
        r_status <= n_status;
        r_p1     <= n_p1;
        r_p2     <= n_p2;
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = '{code_word:       r_word,
                           status:          r_status,
                           first_position:  r_p1,
                           second_position: r_p2};

endmodule
`default_nettype wire

### rtl/block_code_16_8_codec.sv
`default_nettype none
// Systematic (16,8) block encoder and syndrome decoder with the 8x16
// parity-check matrix held in eight APB registers (row r at byte address 4*r).
// One beat is processed at a time. Encoding, and decoding of a clean word, go
// from acceptance to the done state, then on to the result register. A word
// with a nonzero syndrome goes to a sequencer driving one shared column
// compare unit: 16 single columns, then the 120 column pairs, one compare per
// cycle, until a match is found or the last pair fails. The result register
// lets a new beat be accepted while the previous result still waits on the
// master side.
module block_code_16_8_codec (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [bcc_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // data_byte [7:0], received_word [23:8]
    input  wire logic        s_axis_tuser,   // action
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // code_word [15:0], first_position [20:16],
                                             // second_position [25:21], zero [31:26]
    output logic [1:0]       m_axis_tuser    // status
);

    bcc_pkg::t_rows   rows;
    bcc_pkg::t_result core_res;
    bcc_pkg::t_result r_out;
    logic             r_out_valid;
    logic             core_idle;
    logic             core_res_valid;
    logic             slot_free;
    logic             res_taken;

    bcc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rows  (rows)
    );

    bcc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rows          (rows),
        .i_start         (s_axis_tvalid && s_axis_tready),
        .i_action        (s_axis_tuser),
        .i_data_byte     (s_axis_tdata[7:0]),
        .i_received_word (s_axis_tdata[23:8]),
        .i_res_taken     (res_taken),
        .o_idle          (core_idle),
        .o_res_valid     (core_res_valid),
        .o_res           (core_res)
    );

    assign s_axis_tready = core_idle;

    // result register towards the master side
    assign slot_free = !r_out_valid || m_axis_tready;
    assign res_taken = core_res_valid && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= core_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_taken) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.second_position, r_out.first_position,
                            r_out.code_word};
    assign m_axis_tuser  = r_out.status;

endmodule
`default_nettype wire

### verif/tb_top.sv
module tb_top;

    // input beat selector
    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // register map: check row r at byte address r * ROW_STRIDE
    localparam int ROW_STRIDE = 4;

    localparam int RUN_LIMIT = 4000000;

    typedef struct packed {
        logic        act;
        logic [7:0]  data_b;
        logic [15:0] rx;
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // data_byte [7:0], received_word [23:8]
    logic        s_axis_tuser = 1'b0; // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // code_word [15:0], first_position [20:16],
                                      // second_position [25:21], zero [31:26]
    logic [1:0]  m_axis_tuser;        // status

    // testbench copy of the check matrix and its columns
    logic [15:0] check_rows [bcc_pkg::NumRows];
    logic [15:0] next_rows [bcc_pkg::NumRows];
    logic [7:0]  cols [bcc_pkg::NumPos];

    t_job             jobs_q [$];
    bcc_pkg::t_result expected_results_q [$];
    int      mismatch_count = 0;
    int      gap_left = 0;
    int      burst_left = 8;
    int      cycle_count = 0;
    logic [15:0] stall_pat = 16'hFFFF;

    block_code_16_8_codec u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // expected encoder output or syndrome correction for one beat
    function automatic bcc_pkg::t_result predict_codec(input logic act,
                                                       input logic [7:0] data_b,
                                                       input logic [15:0] rx);
        bcc_pkg::t_result res;
        logic [7:0] syn;
        logic [7:0] col [bcc_pkg::NumPos];
        logic       found;
        res.code_word       = '0;
        res.status          = bcc_pkg::ST_CLEAN;
        res.first_position  = bcc_pkg::POS_NONE;
        res.second_position = bcc_pkg::POS_NONE;
        if (act == ACT_ENCODE) begin
            for (int i = 0; i < 8; i++) res.code_word[i] = data_b[7-i];
            for (int r = 0; r < bcc_pkg::NumRows; r++) begin
                res.code_word[8+r] = ^(res.code_word[7:0] & check_rows[r][7:0]);
            end
        end else begin
            res.code_word = rx;
            syn = '0;
            for (int r = 0; r < bcc_pkg::NumRows; r++) syn[r] = ^(rx & check_rows[r]);
            if (syn != 0) begin
                found = 1'b0;
                for (int n = 0; n < bcc_pkg::NumPos; n++) begin
                    for (int r = 0; r < bcc_pkg::NumRows; r++) col[n][r] = check_rows[r][n];
                end
                // single columns first, then pairs in order of i then k
                for (int n = 0; n < bcc_pkg::NumPos && !found; n++) begin
                    if (col[n] == syn) begin
                        found              = 1'b1;
                        res.status         = bcc_pkg::ST_SINGLE;
                        res.first_position = 5'(n);
                    end
                end
                for (int i = 0; i < bcc_pkg::NumPos - 1 && !found; i++) begin
                    for (int k = i + 1; k < bcc_pkg::NumPos && !found; k++) begin
                        if ((col[i] ^ col[k]) == syn) begin
                            found               = 1'b1;
                            res.status          = bcc_pkg::ST_DOUBLE;
                            res.first_position  = 5'(i);
                            res.second_position = 5'(k);
                        end
                    end
                end
                if (!found) begin
                    res.status = bcc_pkg::ST_UNCORR;
                end else begin
                    res.code_word[res.first_position[3:0]] =
                        ~res.code_word[res.first_position[3:0]];
                    if (res.status == bcc_pkg::ST_DOUBLE) begin
                        res.code_word[res.second_position[3:0]] =
                            ~res.code_word[res.second_position[3:0]];
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic apb_write(input int idx, input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx * ROW_STRIDE);
        pwdata  <= {16'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_rows[idx] = val;
    endtask

    // write the staged matrix and refresh the column view
    task automatic load_matrix();
        for (int r = 0; r < bcc_pkg::NumRows; r++) apb_write(r, next_rows[r]);
        for (int n = 0; n < bcc_pkg::NumPos; n++) begin
            for (int r = 0; r < bcc_pkg::NumRows; r++) cols[n][r] = check_rows[r][n];
        end
    endtask

    task automatic push_job(input logic act, input logic [7:0] data_b, input logic [15:0] rx);
        t_job job;
        job.act    = act;
        job.data_b = data_b;
        job.rx     = rx;
        jobs_q.push_back(job);
    endtask

    // encode beats, and decode beats: mostly valid codewords with a few bit errors, some raw noise
    task automatic add_random_jobs(input int count);
        logic [15:0]      cw;
        int               pick;
        bcc_pkg::t_result enc_res;
        for (int j = 0; j < count; j++) begin
            if ($urandom_range(0, 2) == 0) begin
                push_job(ACT_ENCODE, 8'($urandom), 16'($urandom));
            end else begin
                enc_res = predict_codec(ACT_ENCODE, 8'($urandom), '0);
                cw   = enc_res.code_word;
                pick = $urandom_range(0, 9);
                if (pick >= 2) cw[$urandom_range(0, 15)] ^= 1'b1;
                if (pick >= 5) cw[$urandom_range(0, 15)] ^= 1'b1;
                if (pick == 7) cw[$urandom_range(0, 15)] ^= 1'b1;
                if (pick >= 8) cw = 16'($urandom);
                push_job(ACT_DECODE, 8'($urandom), cw);
            end
        end
    endtask

    // block idle: nothing queued, presented or outstanding
    task automatic drain();
        do @(negedge i_clk);
        while (jobs_q.size() != 0 || expected_results_q.size() != 0 || s_axis_tvalid);
    endtask

    // driver: bursts of beats separated by random gaps
    always @(posedge i_clk) begin
        t_job job;
        logic next_valid;
        next_valid = s_axis_tvalid;
        if (s_axis_tvalid && s_axis_tready) begin
            expected_results_q.push_back(
                predict_codec(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8]));
            next_valid = 1'b0;
        end
        if (!next_valid) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (jobs_q.size() > 0) begin
                job = jobs_q.pop_front();
                s_axis_tdata <= {job.rx, job.data_b};
                s_axis_tuser <= job.act;
                next_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // monitor: check each result beat, stall on a rotating pattern
    always @(posedge i_clk) begin
        bcc_pkg::t_result want;
        logic [15:0]      next_pat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_results_q.size() == 0) begin
                $display("%0t unexpected result: expected none, got tdata %h tuser %h",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_count++;
            end else begin
                want = expected_results_q.pop_front();
                if (m_axis_tdata[15:0] !== want.code_word) begin
                    $display("%0t code_word: expected %h, got %h",
                             $time, want.code_word, m_axis_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.status) begin
                    $display("%0t status: expected %0d, got %0d",
                             $time, want.status, m_axis_tuser);
                    mismatch_count++;
                end
                if (m_axis_tdata[20:16] !== want.first_position) begin
                    $display("%0t first_position: expected %0d, got %0d",
                             $time, want.first_position, m_axis_tdata[20:16]);
                    mismatch_count++;
                end
                if (m_axis_tdata[25:21] !== want.second_position) begin
                    $display("%0t second_position: expected %0d, got %0d",
                             $time, want.second_position, m_axis_tdata[25:21]);
                    mismatch_count++;
                end
            end
        end
        cycle_count++;
        if (cycle_count % 256 == 0) begin
            next_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (next_pat == '0) next_pat = 16'hFFFF;
        end else begin
            next_pat = {stall_pat[14:0], stall_pat[15]};
        end
        stall_pat     <= next_pat;
        m_axis_tready <= next_pat[15];
    end

    // stimulus sequence
    initial begin
        logic [15:0]      cw;
        logic [7:0]       uncorr_syn;
        logic             covered;
        int               a;
        bcc_pkg::t_result enc_res;
        for (int r = 0; r < bcc_pkg::NumRows; r++) check_rows[r] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // matrix still at its reset value: zero parity, zero syndrome
        push_job(ACT_ENCODE, 8'hFF, 16'h0000);
        push_job(ACT_DECODE, 8'h00, 16'hFFFF);
        push_job(ACT_DECODE, 8'hFF, 16'h1234);
        add_random_jobs(40);
        drain();

        // systematic matrix: random parity part, identity on positions 8..15
        for (int r = 0; r < bcc_pkg::NumRows; r++) begin
            next_rows[r] = (16'h1 << (8 + r)) | 16'($urandom_range(0, 255));
        end
        load_matrix();
        uncorr_syn = '0;
        for (int s = 1; s < 256 && uncorr_syn == 0; s++) begin
            covered = 1'b0;
            for (int i = 0; i < bcc_pkg::NumPos; i++) begin
                if (cols[i] == 8'(s)) covered = 1'b1;
                for (int k = i + 1; k < bcc_pkg::NumPos; k++) begin
                    if ((cols[i] ^ cols[k]) == 8'(s)) covered = 1'b1;
                end
            end
            if (!covered) uncorr_syn = 8'(s);
        end
        @(negedge i_clk);
        push_job(ACT_ENCODE, 8'h00, 16'hFFFF);
        push_job(ACT_ENCODE, 8'hFF, 16'h0000);
        push_job(ACT_ENCODE, 8'h80, 16'h5A5A);
        push_job(ACT_ENCODE, 8'h01, 16'hA5A5);
        push_job(ACT_ENCODE, 8'hA5, 16'h0000);
        enc_res = predict_codec(ACT_ENCODE, 8'hA5, '0);
        cw = enc_res.code_word;
        push_job(ACT_DECODE, 8'hFF, cw);
        push_job(ACT_DECODE, 8'h00, cw ^ 16'h0001);
        push_job(ACT_DECODE, 8'h00, cw ^ 16'h8000);
        push_job(ACT_DECODE, 8'h00, cw ^ 16'h0080);
        push_job(ACT_DECODE, 8'h00, cw ^ 16'h1008);
        // syndrome reached by no column and no pair
        push_job(ACT_DECODE, 8'h00, {uncorr_syn, 8'h00});
        push_job(ACT_DECODE, 8'h00, 16'hFFFF);
        push_job(ACT_DECODE, 8'hFF, 16'h0000);
        add_random_jobs(300);
        drain();

        // all ones: every column equal, odd weight fixes position 0
        for (int r = 0; r < bcc_pkg::NumRows; r++) next_rows[r] = 16'hFFFF;
        load_matrix();
        @(negedge i_clk);
        push_job(ACT_DECODE, 8'h00, 16'h8000);
        push_job(ACT_DECODE, 8'h00, 16'h0003);
        add_random_jobs(60);
        drain();

        // degenerate matrix: zero columns and repeated columns
        for (int n = 0; n < bcc_pkg::NumPos; n++) cols[n] = 8'($urandom);
        cols[$urandom_range(0, 15)] = '0;
        cols[$urandom_range(0, 15)] = '0;
        for (int j = 0; j < 3; j++) begin
            a = $urandom_range(0, 15);
            cols[a] = cols[$urandom_range(0, 15)];
        end
        for (int r = 0; r < bcc_pkg::NumRows; r++) begin
            for (int n = 0; n < bcc_pkg::NumPos; n++) next_rows[r][n] = cols[n][r];
        end
        load_matrix();
        @(negedge i_clk);
        add_random_jobs(150);
        drain();

        // fully random matrix
        for (int r = 0; r < bcc_pkg::NumRows; r++) next_rows[r] = 16'($urandom);
        load_matrix();
        @(negedge i_clk);
        add_random_jobs(150);
        drain();

        // back to all zeros
        for (int r = 0; r < bcc_pkg::NumRows; r++) next_rows[r] = '0;
        load_matrix();
        @(negedge i_clk);
        add_random_jobs(20);
        drain();

        // catch any stray result beats
        repeat (150) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #RUN_LIMIT;
        $display("simulation failed");
        $finish;
    end

endmodule
